// ===== src/osmd_pkg.sv =====
// Shared types and constants for the overflow-safe multiply-divide block.
`timescale 1ns / 1ps

package osmd_pkg;

	// Default operand width in bits.
	localparam int DATA_WIDTH_DEF = 32;

	// Operations of the shared add/subtract unit.
	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

endpackage

// ===== src/overflow_safe_mul_div.sv =====
// Top level: approximate signed a*b/c with saturation, built around one shared adder.
`timescale 1ns / 1ps

// Channel  Direction  Handshake           Word
// input    in         in_valid/in_stall   factor_a, factor_b, divisor
// output   out        out_valid/out_stall quotient
//
// One word at a time: the input stalls from acceptance until the result is loaded.
// Exact path: magnitudes, ordering, a shift-and-add pass and the restoring divider.
// Approximate path: a shift-and-add pass, the normalization scan, the restoring divider and
// a second shift-and-add pass, all on the shared adder. A zero factor goes straight to the finish.
// The finish waits while the output register is full and stalled; the block then returns to idle.
// Reset (arst_n low) empties the block; no clearing pass is needed.
// A pending result in the output register does not block acceptance of the next word.

module overflow_safe_mul_div import osmd_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] factor_a,
	input  logic signed [DATA_WIDTH-1:0] factor_b,
	input  logic signed [DATA_WIDTH-1:0] divisor,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] quotient
);

	localparam int W = DATA_WIDTH;
	localparam int CW = $clog2(DATA_WIDTH);
	localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [CW-1:0] LAST = CW'(W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ABS,
		ST_ORDER,
		ST_MUL,
		ST_SCAN,
		ST_DIVIDE,
		ST_FIN
	} state_t;

	state_t          state_q;
	logic [1:0]      abs_cnt_q;
	logic [W-1:0]    a_q, b_q, c_q;
	logic            neg_ab_q, neg_q;
	logic [W-1:0]    mcand_q, mplier_q, acc_q;
	logic            lost_q, ovf_q, approx_q;
	logic [W-1:0]    sh_q, norm_q;
	logic [CW-1:0]   left_q, right_q, s_q, cnt_q;
	logic [W-1:0]    dvd_q, rem_q, res_q, quotient_q;
	logic            out_valid_q;

	alu_op_t         alu_op;
	logic [W+1:0]    alu_x, alu_y, alu_sum;

	logic            swap;
	logic [W-1:0]    mag_max, mag_min, abs_val;
	logic [W:0]      rem_sh;
	logic            div_ok;
	logic [W-1:0]    q_next;
	logic            fits;
	logic            left_done, right_done, right_gt;
	logic [CW-1:0]   s_next;

	osmd_alu #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_alu (
		.op  (alu_op),
		.x   (alu_x),
		.y   (alu_y),
		.sum (alu_sum)
	);

	// Operand selection for the shared unit.
	always_comb begin
		alu_op = ALU_ADD;
		alu_x = '0;
		alu_y = '0;
		case (state_q)
			ST_ABS: begin
				alu_op = ALU_SUB;
				alu_y = {2'b00, a_q};
			end
			ST_MUL: begin
				alu_x = {2'b00, acc_q};
				alu_y = {2'b00, mcand_q};
			end
			ST_SCAN: begin
				alu_op = ALU_SUB;
				alu_x = {2'b00, c_q};
				alu_y = {2'b00, sh_q};
			end
			ST_DIVIDE: begin
				alu_op = ALU_SUB;
				alu_x = {1'b0, rem_sh};
				alu_y = {2'b00, c_q};
			end
			ST_FIN: begin
				alu_op = ALU_SUB;
				alu_y = {2'b00, res_q};
			end
			default: begin
			end
		endcase
	end

	assign swap = b_q > a_q;
	assign mag_max = swap ? b_q : a_q;
	assign mag_min = swap ? a_q : b_q;
	assign abs_val = a_q[W-1] ? alu_sum[W-1:0] : a_q;

	assign rem_sh = {rem_q, dvd_q[W-1]};
	assign div_ok = !alu_sum[W+1];
	assign q_next = {dvd_q[W-2:0], div_ok};

	// The product fits when it stays at or below the largest magnitude of its sign.
	assign fits = !ovf_q && (!acc_q[W-1] || (neg_ab_q && acc_q == HALF));

	assign left_done = norm_q[W-2];
	assign right_done = !alu_sum[W+1];
	assign right_gt = right_q > left_q;
	assign s_next = left_q - right_q;

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign quotient = quotient_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			abs_cnt_q <= '0;
			cnt_q <= '0;
			approx_q <= 1'b0;
		end else begin
			// The finishing state sets the flag itself when it loads a new word.
			if (out_valid_q && !out_stall && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						a_q <= factor_a;
						b_q <= factor_b;
						c_q <= divisor;
						neg_ab_q <= factor_a[W-1] ^ factor_b[W-1];
						neg_q <= factor_a[W-1] ^ factor_b[W-1] ^ divisor[W-1];
						abs_cnt_q <= '0;
						state_q <= ST_ABS;
					end
				end
				ST_ABS: begin
					// Rotate the three operands through the shared negator.
					a_q <= b_q;
					b_q <= c_q;
					c_q <= abs_val;
					abs_cnt_q <= abs_cnt_q + 2'd1;
					if (abs_cnt_q == 2'd2) begin
						state_q <= ST_ORDER;
					end
				end
				ST_ORDER: begin
					if (a_q == '0 || b_q == '0) begin
						res_q <= '0;
						state_q <= ST_FIN;
					end else begin
						a_q <= mag_max;
						b_q <= mag_min;
						mcand_q <= mag_max;
						mplier_q <= mag_min;
						acc_q <= '0;
						lost_q <= 1'b0;
						ovf_q <= 1'b0;
						approx_q <= 1'b0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mplier_q == '0) begin
						if (approx_q) begin
							res_q <= acc_q >> s_q;
							state_q <= ST_FIN;
						end else if (fits && c_q != '0) begin
							dvd_q <= acc_q;
							rem_q <= '0;
							cnt_q <= '0;
							state_q <= ST_DIVIDE;
						end else if (c_q == '0 || a_q == HALF || c_q == HALF) begin
							res_q <= SMAX;
							state_q <= ST_FIN;
						end else begin
							sh_q <= b_q;
							norm_q <= a_q;
							left_q <= '0;
							right_q <= '0;
							state_q <= ST_SCAN;
						end
					end else begin
						// A carry out of the word, or an add after a set bit has left the multiplicand, means overflow.
						if (mplier_q[0]) begin
							acc_q <= alu_sum[W-1:0];
							if (alu_sum[W] || lost_q) begin
								ovf_q <= 1'b1;
							end
						end
						lost_q <= lost_q | mcand_q[W-1];
						mcand_q <= mcand_q << 1;
						mplier_q <= mplier_q >> 1;
					end
				end
				ST_SCAN: begin
					if (left_done && right_done) begin
						if (right_gt) begin
							res_q <= SMAX;
							state_q <= ST_FIN;
						end else begin
							s_q <= s_next;
							dvd_q <= a_q << s_next;
							rem_q <= '0;
							cnt_q <= '0;
							approx_q <= 1'b1;
							state_q <= ST_DIVIDE;
						end
					end else begin
						if (!left_done) begin
							norm_q <= norm_q << 1;
							left_q <= left_q + CW'(1);
						end
						if (!right_done) begin
							sh_q <= sh_q >> 1;
							right_q <= right_q + CW'(1);
						end
					end
				end
				ST_DIVIDE: begin
					rem_q <= div_ok ? alu_sum[W-1:0] : rem_sh[W-1:0];
					dvd_q <= q_next;
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == LAST) begin
						if (approx_q) begin
							mcand_q <= q_next;
							mplier_q <= b_q;
							acc_q <= '0;
							lost_q <= 1'b0;
							ovf_q <= 1'b0;
							state_q <= ST_MUL;
						end else begin
							res_q <= (!neg_q && q_next[W-1]) ? SMAX : q_next;
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (!out_valid_q || !out_stall) begin
						quotient_q <= neg_q ? alu_sum[W-1:0] : res_q;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_ABS && in_stall))
		else $error("accepted word did not start the magnitude phase");

	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && (!out_valid || !out_stall)) |=>
		(out_valid && state_q == ST_IDLE))
		else $error("finished result was not loaded into the output register");

	a_scan_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (right_q <= CW'(W - 2) && left_q <= CW'(W - 2)))
		else $error("normalization shift count out of range");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE) |-> (rem_q < c_q))
		else $error("partial remainder not below divisor");

endmodule

// ===== src/osmd_alu.sv =====
// Shared add/subtract unit, two bits wider than the operands for carry and borrow.
`timescale 1ns / 1ps

module osmd_alu import osmd_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  alu_op_t                 op,
	input  logic [DATA_WIDTH+1:0]   x,
	input  logic [DATA_WIDTH+1:0]   y,
	output logic [DATA_WIDTH+1:0]   sum
);

	always_comb begin
		case (op)
			ALU_ADD: sum = x + y;
			ALU_SUB: sum = x - y;
			default: sum = x + y;
		endcase
	end

endmodule

// ===== tb/overflow_safe_mul_div_tb.sv =====
// Self-checking testbench for the overflow-safe multiply-divide block.
`timescale 1ns / 1ps

module overflow_safe_mul_div_tb;
	import osmd_pkg::*;

	localparam int DW = DATA_WIDTH_DEF;
	localparam int DRAIN_WAIT = 3 * DW + 30;

	typedef logic signed [DW-1:0] operand_t;

	typedef struct {
		operand_t factor_a;
		operand_t factor_b;
		operand_t divisor;
		bit       drain;
	} mul_div_word_t;

	localparam operand_t MAXV = {1'b0, {(DW-1){1'b1}}};
	localparam operand_t MINV = {1'b1, {(DW-1){1'b0}}};

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_stall;
	operand_t factor_a = '0;
	operand_t factor_b = '0;
	operand_t divisor = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	operand_t quotient;

	mul_div_word_t pending_q[$];
	operand_t      quotient_q[$];
	logic          in_fire = 1'b0;
	int            accepted_count = 0;
	int            result_count = 0;
	int            mismatches = 0;

	overflow_safe_mul_div #(
		.DATA_WIDTH(DW)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.factor_a (factor_a),
		.factor_b (factor_b),
		.divisor  (divisor),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.quotient (quotient)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] magnitude(operand_t v);
		logic [63:0] mag;
		mag = v[DW-1] ? ((64'd0 - 64'(unsigned'(v))) & ({64{1'b1}} >> (64 - DW)))
			: 64'(unsigned'(v));
		if (v[DW-1] && mag == 0) begin
			mag = 64'd1 << (DW - 1);
		end
		return mag;
	endfunction

	function automatic operand_t with_sign(logic [63:0] mag, logic neg);
		return operand_t'(neg ? 64'd0 - mag : mag);
	endfunction

	function automatic operand_t predict_quotient(operand_t a, operand_t b, operand_t c);
		logic [63:0] mask, half, smax, ma, mb, mc, q, t;
		logic        neg_ab, neg;
		int          nbits, left, right, s;
		mask = {64{1'b1}} >> (64 - DW);
		half = 64'd1 << (DW - 1);
		smax = half - 1;
		ma = magnitude(a);
		mb = magnitude(b);
		mc = magnitude(c);
		neg_ab = a[DW-1] ^ b[DW-1];
		neg = neg_ab ^ c[DW-1];
		if (ma == 0 || mb == 0) begin
			return '0;
		end
		// The product fits: plain truncating divide, with most negative over minus one clipped.
		if (mc != 0 && ma <= (neg_ab ? half : smax) / mb) begin
			q = (ma * mb) / mc;
			if (!neg && q > smax) begin
				q = smax;
			end
			return with_sign(q, neg);
		end
		if (mc == 0 || ma == half || mb == half || mc == half) begin
			return with_sign(smax, neg);
		end
		if (mb > ma) begin
			t = ma;
			ma = mb;
			mb = t;
		end
		nbits = 0;
		t = ma;
		while (t != 0) begin
			t = t >> 1;
			nbits++;
		end
		left = DW - 1 - nbits;
		right = 0;
		while (right < 63 && (mb >> right) > mc) begin
			right++;
		end
		if (right > left) begin
			return with_sign(smax, neg);
		end
		s = left - right;
		// Divide first, multiply after; the product wraps at the word width.
		q = ((((ma << s) / mc) * mb) & mask) >> s;
		return with_sign(q, neg);
	endfunction

	task automatic queue_word(operand_t a, operand_t b, operand_t c, bit drain);
		mul_div_word_t w;
		w.factor_a = a;
		w.factor_b = b;
		w.divisor = c;
		w.drain = drain;
		pending_q.push_back(w);
	endtask

	// A value of exactly nbits significant bits, negated half the time.
	function automatic operand_t scaled_value(int nbits);
		logic [63:0] r;
		operand_t    v;
		r = {$urandom, $urandom};
		v = operand_t'((r & ((64'd1 << (nbits - 1)) - 1)) | (64'd1 << (nbits - 1)));
		return $urandom_range(1, 0) ? -v : v;
	endfunction

	function automatic operand_t full_random();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return operand_t'(r);
	endfunction

	function automatic operand_t corner_or_random();
		case ($urandom_range(9, 0))
			0: begin
				return '0;
			end
			1: begin
				return operand_t'(1);
			end
			2: begin
				return operand_t'(-1);
			end
			3: begin
				return MAXV;
			end
			4: begin
				return MINV;
			end
			default: begin
				return full_random();
			end
		endcase
	endfunction

	// Sender: presents the next word once the current one is taken, idling now and then.
	always @(negedge clk) begin
		logic calm;
		calm = accepted_count >= 150 && accepted_count < 260;
		if (arst_n && (!in_valid || in_fire)) begin
			if (pending_q.size() == 0) begin
				in_valid <= 1'b0;
			end else if (pending_q[0].drain && quotient_q.size() != 0) begin
				in_valid <= 1'b0;
			end else if (!calm && $urandom_range(99, 0) < 19) begin
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				factor_a <= pending_q[0].factor_a;
				factor_b <= pending_q[0].factor_b;
				divisor <= pending_q[0].divisor;
				void'(pending_q.pop_front());
			end
		end
	end

	// Receiver stall, drawn anew on every cycle so it lands on all phases of the block; off for a window of results.
	always @(negedge clk) begin
		if (result_count >= 150 && result_count < 260) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= $urandom_range(99, 0) < 19;
		end
	end

	always @(posedge clk) begin
		operand_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				result_count++;
				if (quotient_q.size() == 0) begin
					$error("quotient: expected none, actual %0d", quotient);
					mismatches++;
				end else begin
					want = quotient_q.pop_front();
					if (quotient !== want) begin
						$error("quotient: expected %0d, actual %0d", want, quotient);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				quotient_q.push_back(predict_quotient(factor_a, factor_b, divisor));
				accepted_count++;
			end
			in_fire <= in_valid && !in_stall;
		end
	end

	initial begin
		int mode;
		int la;
		int lb;
		operand_t a;
		operand_t b;
		operand_t c;

		queue_word(0, 5, 3, 1'b0);
		queue_word(7, 0, 0, 1'b0);
		queue_word(6, 7, 3, 1'b0);
		queue_word(-6, 7, 4, 1'b0);
		queue_word(5, 3, 0, 1'b0);
		queue_word(-5, 3, 0, 1'b0);
		queue_word(MINV, 1, -1, 1'b0);
		queue_word(MINV, -1, 1, 1'b0);
		queue_word(MINV, 1, 1, 1'b0);
		queue_word(MINV, 2, 3, 1'b0);
		queue_word(2, 3, MINV, 1'b0);
		queue_word(MAXV, MAXV, MAXV, 1'b1);
		queue_word(MAXV, MAXV, 1, 1'b0);
		queue_word(MAXV, -MAXV, 2, 1'b0);
		queue_word(operand_t'(32'h10000), operand_t'(32'h10000), operand_t'(32'h100), 1'b0);
		// The rescaled product lands above the signed range and comes out negative.
		queue_word(operand_t'(32'h3FFFFFFF), 3, 1, 1'b0);
		queue_word(-operand_t'(32'h3FFFFFFF), 3, -1, 1'b0);
		queue_word(1, 1, 1, 1'b0);
		queue_word(-1, -1, -1, 1'b0);
		queue_word(MAXV, 1, -1, 1'b0);
		queue_word(MINV, MINV, 5, 1'b0);
		queue_word(MAXV, 2, MINV, 1'b0);
		queue_word(12345, -67890, 7, 1'b0);

		for (int i = 0; i < 500; i++) begin
			mode = $urandom_range(9, 0);
			case (mode)
				0, 1, 2: begin
					a = full_random();
					b = full_random();
					c = full_random();
				end
				3, 4, 5: begin
					// Product too wide for the word, so the rescaling path does the work.
					la = $urandom_range(DW - 2, DW / 2 + 1);
					lb = $urandom_range(DW - 2, DW + 1 - la);
					a = scaled_value(la);
					b = scaled_value(lb);
					c = scaled_value($urandom_range(DW - 2, 1));
				end
				6, 7: begin
					a = scaled_value($urandom_range(DW, 1));
					b = scaled_value($urandom_range(DW, 1));
					c = scaled_value($urandom_range(DW, 1));
				end
				8: begin
					a = operand_t'($urandom_range(16, 0)) - 8;
					b = operand_t'($urandom_range(16, 0)) - 8;
					c = operand_t'($urandom_range(16, 0)) - 8;
				end
				default: begin
					a = corner_or_random();
					b = corner_or_random();
					c = corner_or_random();
				end
			endcase
			queue_word(a, b, c, i % 125 == 0);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || in_valid) begin
			@(posedge clk);
		end
		while (quotient_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#6000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
